// ----- src/lrhc_pkg.sv -----
// ----------------------------------------------------------------------------
// lrhc_pkg
// Shared types and constants of the HWC/CHW layout reorder block.
// ----------------------------------------------------------------------------
`default_nettype none

package lrhc_pkg;

	localparam int MAX_ELEMENTS = 16384;
	localparam int ELEMENT_BITS = 32;
	localparam int ADDR_W       = $clog2(MAX_ELEMENTS);

	localparam int CNT_W        = 15;
	localparam int CH_W         = 4;
	localparam int CHN_W        = 5;
	localparam int DIR_W        = 2;
	localparam int PIX_FULL_W   = 2 * CNT_W;
	localparam int TOT_FULL_W   = PIX_FULL_W + CHN_W;

	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 15;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd3;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_PULL = 1'b1;

	localparam logic [DIR_W-1:0] DIR_HWC_CHW = 2'd0;
	localparam logic [DIR_W-1:0] DIR_CHW_HWC = 2'd1;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NOT_READY  = 2'd1,
		ST_SIZE_ERROR = 2'd2
	} status_t;

	typedef struct packed {
		logic [CNT_W-1:0] pixels;
		logic [CNT_W-1:0] total;
		logic [CHN_W-1:0] channels;
		logic [DIR_W-1:0] direction;
		logic             size_ok;
		logic             busy;
		logic             clear;
	} geom_t;

	typedef struct packed {
		logic loaded_full;
		logic pull_ok;
		logic read_last;
	} addr_stat_t;

endpackage

`default_nettype wire

// ----- src/lrhc_ram.sv -----
// ----------------------------------------------------------------------------
// lrhc_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lrhc_ram #(
	parameter int DEPTH = 16384,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- src/lrhc_geom.sv -----
// ----------------------------------------------------------------------------
// lrhc_geom
// Configuration registers and a two-stage pipeline for pixel and element count.
// ----------------------------------------------------------------------------
`default_nettype none

module lrhc_geom (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [lrhc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lrhc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output lrhc_pkg::geom_t                        geom
);

	logic [lrhc_pkg::CNT_W-1:0]      width_q;
	logic [lrhc_pkg::CNT_W-1:0]      height_q;
	logic [lrhc_pkg::CHN_W-1:0]      channels_q;
	logic [lrhc_pkg::DIR_W-1:0]      direction_q;
	logic                            pend_s1;
	logic                            pend_s2;
	logic                            dims_ok_s1;
	logic [lrhc_pkg::CHN_W-1:0]      channels_s1;
	logic [lrhc_pkg::PIX_FULL_W-1:0] pix_s1;
	logic [lrhc_pkg::TOT_FULL_W-1:0] tot_full;
	logic [lrhc_pkg::CNT_W-1:0]      pixels_q;
	logic [lrhc_pkg::CNT_W-1:0]      total_q;
	logic                            size_ok_q;
	logic                            reg_hit;

	always_comb begin
		reg_hit = 1'b0;
		case (cfg_index)
			lrhc_pkg::REG_WIDTH,
			lrhc_pkg::REG_HEIGHT,
			lrhc_pkg::REG_CHANNELS,
			lrhc_pkg::REG_DIRECTION: reg_hit = 1'b1;
			default: reg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= lrhc_pkg::CNT_W'(1);
			height_q    <= lrhc_pkg::CNT_W'(1);
			channels_q  <= lrhc_pkg::CHN_W'(3);
			direction_q <= lrhc_pkg::DIR_HWC_CHW;
		end else if (cfg_we) begin
			case (cfg_index)
				lrhc_pkg::REG_WIDTH:     width_q     <= cfg_data;
				lrhc_pkg::REG_HEIGHT:    height_q    <= cfg_data;
				lrhc_pkg::REG_CHANNELS:  channels_q  <= cfg_data[lrhc_pkg::CHN_W-1:0];
				lrhc_pkg::REG_DIRECTION: direction_q <= cfg_data[lrhc_pkg::DIR_W-1:0];
				default: ;
			endcase
		end
	end

	// hold off items after reset or a write to a defined register, while pend_s1 or pend_s2 is set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b1;
			pend_s2 <= 1'b1;
		end else begin
			pend_s1 <= cfg_we && reg_hit;
			pend_s2 <= pend_s1;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1      <= lrhc_pkg::PIX_FULL_W'(width_q) * lrhc_pkg::PIX_FULL_W'(height_q);
		channels_s1 <= channels_q;
		dims_ok_s1  <= (width_q != '0) && (height_q != '0) && (channels_q != '0)
			&& (channels_q <= lrhc_pkg::CHN_W'(16));
	end

	assign tot_full = lrhc_pkg::TOT_FULL_W'(pix_s1) * lrhc_pkg::TOT_FULL_W'(channels_s1);

	always_ff @(posedge clk) begin
		pixels_q  <= pix_s1[lrhc_pkg::CNT_W-1:0];
		total_q   <= tot_full[lrhc_pkg::CNT_W-1:0];
		size_ok_q <= dims_ok_s1
			&& (tot_full <= lrhc_pkg::TOT_FULL_W'(lrhc_pkg::MAX_ELEMENTS));
	end

	always_comb begin
		geom.pixels    = pixels_q;
		geom.total     = total_q;
		geom.channels  = channels_q;
		geom.direction = direction_q;
		geom.size_ok   = size_ok_q;
		geom.busy      = pend_s1 || pend_s2;
		geom.clear     = cfg_we && reg_hit;
	end

endmodule

`default_nettype wire

// ----- src/lrhc_addr.sv -----
// ----------------------------------------------------------------------------
// lrhc_addr
// Pixel and channel counters giving store write and read addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module lrhc_addr (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire lrhc_pkg::geom_t              geom,
	input  wire logic                         load_go,
	input  wire logic                         pull_go,
	output logic [lrhc_pkg::ADDR_W-1:0]       wr_addr,
	output logic [lrhc_pkg::ADDR_W-1:0]       rd_addr,
	output lrhc_pkg::addr_stat_t              stat
);

	logic [lrhc_pkg::CNT_W-1:0] px_q;
	logic [lrhc_pkg::CH_W-1:0]  ch_q;
	logic [lrhc_pkg::CNT_W-1:0] loaded_q;
	logic [lrhc_pkg::CNT_W-1:0] rd_idx_q;
	logic [lrhc_pkg::CNT_W-1:0] dest_q;
	logic [lrhc_pkg::CNT_W:0]   px_inc;
	logic [lrhc_pkg::CHN_W-1:0] ch_inc;
	logic                       px_wrap;
	logic                       ch_wrap;
	logic                       loaded_full;

	assign px_inc  = {1'b0, px_q} + 1'b1;
	assign ch_inc  = {1'b0, ch_q} + 1'b1;
	assign px_wrap = px_inc >= {1'b0, geom.pixels};
	assign ch_wrap = ch_inc >= geom.channels;

	assign loaded_full = loaded_q >= geom.total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q     <= '0;
			ch_q     <= '0;
			loaded_q <= '0;
			rd_idx_q <= '0;
			dest_q   <= '0;
		end else if (geom.clear || (pull_go && stat.read_last)) begin
			px_q     <= '0;
			ch_q     <= '0;
			loaded_q <= '0;
			rd_idx_q <= '0;
			dest_q   <= '0;
		end else if (pull_go) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end else if (load_go) begin
			loaded_q <= loaded_q + 1'b1;
			case (geom.direction)
				lrhc_pkg::DIR_HWC_CHW: begin
					if (ch_wrap) begin
						ch_q   <= '0;
						px_q   <= px_inc[lrhc_pkg::CNT_W-1:0];
						dest_q <= px_inc[lrhc_pkg::CNT_W-1:0];
					end else begin
						ch_q   <= ch_inc[lrhc_pkg::CH_W-1:0];
						dest_q <= dest_q + geom.pixels;
					end
				end
				lrhc_pkg::DIR_CHW_HWC: begin
					if (px_wrap) begin
						px_q   <= '0;
						ch_q   <= ch_inc[lrhc_pkg::CH_W-1:0];
						dest_q <= lrhc_pkg::CNT_W'(ch_inc);
					end else begin
						px_q   <= px_inc[lrhc_pkg::CNT_W-1:0];
						dest_q <= dest_q + lrhc_pkg::CNT_W'(geom.channels);
					end
				end
				default: begin
					dest_q <= dest_q + 1'b1;
				end
			endcase
		end
	end

	assign wr_addr = dest_q[lrhc_pkg::ADDR_W-1:0];
	assign rd_addr = rd_idx_q[lrhc_pkg::ADDR_W-1:0];

	always_comb begin
		stat.loaded_full = loaded_full;
		stat.pull_ok     = loaded_full && (rd_idx_q < geom.total);
		stat.read_last   = rd_idx_q == (geom.total - 1'b1);
	end

endmodule

`default_nettype wire

// ----- src/layout_reorder_hwc_chw_core.sv -----
// ----------------------------------------------------------------------------
// layout_reorder_hwc_chw_core
// Reorders one tensor between interleaved (HWC) and planar (CHW) layouts, or copies it as is.
// ----------------------------------------------------------------------------
// Throughput: one command per cycle while in_stall is low, loads and pulls alike.
// Output: a pull's result is presented in the cycle after its transfer, set by
//   the registered read port of the element store.
// Reset: registers return to 1x1x3, HWC to CHW; counters clear; store contents
//   stay undefined. Input stalls after reset and after each write to a defined
//   register while the size pipeline settles.
// ----------------------------------------------------------------------------
`default_nettype none

module layout_reorder_hwc_chw_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lrhc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lrhc_pkg::CFG_DATA_W-1:0]   cfg_data,

	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              cmd,
	input  wire logic [lrhc_pkg::ELEMENT_BITS-1:0] element,

	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [lrhc_pkg::ELEMENT_BITS-1:0] element_out,
	output logic                                   last,
	output logic      [1:0]                        status
);

	lrhc_pkg::geom_t                   geom;
	lrhc_pkg::addr_stat_t              stat;
	lrhc_pkg::status_t                 res_status;
	lrhc_pkg::status_t                 status_q;
	logic [lrhc_pkg::ADDR_W-1:0]       wr_addr;
	logic [lrhc_pkg::ADDR_W-1:0]       rd_addr;
	logic [lrhc_pkg::ELEMENT_BITS-1:0] rd_data;
	logic                              in_xfer;
	logic                              load_go;
	logic                              pull_go;
	logic                              has_res;
	logic                              out_valid_q;
	logic                              last_q;

	assign cfg_ready = 1'b1;

	lrhc_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	assign in_stall = geom.busy || (out_valid_q && out_stall);
	assign in_xfer  = in_valid && !in_stall;

	always_comb begin
		load_go    = 1'b0;
		pull_go    = 1'b0;
		has_res    = 1'b0;
		res_status = lrhc_pkg::ST_OK;
		if (!geom.size_ok) begin
			has_res    = 1'b1;
			res_status = lrhc_pkg::ST_SIZE_ERROR;
		end else if (cmd == lrhc_pkg::CMD_LOAD) begin
			load_go = !stat.loaded_full;
		end else begin
			has_res = 1'b1;
			if (stat.pull_ok) begin
				pull_go = 1'b1;
			end else begin
				res_status = lrhc_pkg::ST_NOT_READY;
			end
		end
	end

	lrhc_addr u_addr (
		.clk     (clk),
		.arst_n  (arst_n),
		.geom    (geom),
		.load_go (in_xfer && load_go),
		.pull_go (in_xfer && pull_go),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.stat    (stat)
	);

	lrhc_ram #(
		.DEPTH (lrhc_pkg::MAX_ELEMENTS),
		.WIDTH (lrhc_pkg::ELEMENT_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (in_xfer && load_go),
		.wr_addr (wr_addr),
		.wr_data (element),
		.rd_en   (in_xfer && pull_go),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer && has_res) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && has_res) begin
			status_q <= res_status;
			last_q   <= pull_go && stat.read_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign element_out = (status_q == lrhc_pkg::ST_OK) ? rd_data : '0;
	assign last        = last_q;
	assign status      = status_q;

endmodule

`default_nettype wire

// ----- bench/layout_reorder_hwc_chw_core_test.sv -----
// ----------------------------------------------------------------------------
// layout_reorder_hwc_chw_core_test
// Self-checking bench for the HWC/CHW layout reorder core. A queue-fed driver
// sends load and pull commands under random idle bursts while a monitor with
// random stall bursts checks every result against an in-bench reorder
// predictor. Geometry is rewritten between phases: directed corner cases, a
// full-capacity size check, then random tensors with early pulls, surplus
// loads, cut-short loads and invalid sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module layout_reorder_hwc_chw_core_test;

	localparam logic [lrhc_pkg::DIR_W-1:0]     DIR_COPY        = 2'd2;
	localparam logic [lrhc_pkg::DIR_W-1:0]     DIR_COPY_ALT    = 2'd3;
	localparam logic [lrhc_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd4;
	localparam logic [lrhc_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	localparam int RANDOM_ITEMS   = 950;
	localparam int QUIET_FROM     = 820;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic                              op;
		logic [lrhc_pkg::ELEMENT_BITS-1:0] data;
	} cmd_item_t;

	typedef struct packed {
		logic [lrhc_pkg::ELEMENT_BITS-1:0] data;
		logic                              last;
		lrhc_pkg::status_t                 status;
	} reorder_result_t;

	logic                              clk;
	logic                              arst_n    = 1'b0;
	logic                              cfg_valid = 1'b0;
	logic [lrhc_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
	logic [lrhc_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;
	logic                              in_valid  = 1'b0;
	logic                              cmd       = lrhc_pkg::CMD_LOAD;
	logic [lrhc_pkg::ELEMENT_BITS-1:0] element   = '0;
	logic                              out_stall = 1'b0;
	logic                              cfg_ready;
	logic                              in_stall;
	logic                              out_valid;
	logic [lrhc_pkg::ELEMENT_BITS-1:0] element_out;
	logic                              last;
	logic [1:0]                        status;

	layout_reorder_hwc_chw_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.element     (element),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.element_out (element_out),
		.last        (last),
		.status      (status)
	);

	cmd_item_t       cmd_queue[$];
	reorder_result_t expected_q[$];
	int              queued_items = 0;
	int              mismatches   = 0;
	int              result_no    = 0;
	int              send_gap     = 0;
	int              stall_left   = 0;
	int              idle_cycles  = 0;
	bit              quiet        = 1'b0;

	logic [lrhc_pkg::CNT_W-1:0]        geo_w;
	logic [lrhc_pkg::CNT_W-1:0]        geo_h;
	logic [lrhc_pkg::CHN_W-1:0]        geo_c;
	logic [lrhc_pkg::DIR_W-1:0]        geo_d;
	longint unsigned                   pix_cnt;
	longint unsigned                   ch_cnt;
	longint unsigned                   load_cnt;
	longint unsigned                   rd_idx;
	logic [lrhc_pkg::ELEMENT_BITS-1:0] img_store [lrhc_pkg::MAX_ELEMENTS];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic void empty_tensor();
		pix_cnt  = 0;
		ch_cnt   = 0;
		load_cnt = 0;
		rd_idx   = 0;
	endfunction

	function automatic void apply_reg(input logic [lrhc_pkg::CFG_IDX_W-1:0] idx,
			input logic [lrhc_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			lrhc_pkg::REG_WIDTH: begin
				geo_w = data;
				empty_tensor();
			end
			lrhc_pkg::REG_HEIGHT: begin
				geo_h = data;
				empty_tensor();
			end
			lrhc_pkg::REG_CHANNELS: begin
				geo_c = data[lrhc_pkg::CHN_W-1:0];
				empty_tensor();
			end
			lrhc_pkg::REG_DIRECTION: begin
				geo_d = data[lrhc_pkg::DIR_W-1:0];
				empty_tensor();
			end
			default: ;
		endcase
	endfunction

	function automatic longint unsigned tensor_elems();
		longint unsigned n;
		n = geo_w;
		n = n * geo_h;
		n = n * geo_c;
		if (geo_w == 0 || geo_h == 0 || geo_c == 0 || geo_c > 16
				|| n > lrhc_pkg::MAX_ELEMENTS)
			n = 0;
		return n;
	endfunction

	task automatic predict_reorder(input logic op,
			input logic [lrhc_pkg::ELEMENT_BITS-1:0] data);
		longint unsigned total;
		longint unsigned pixels;
		longint unsigned dest;
		reorder_result_t res;
		total      = tensor_elems();
		pixels     = geo_w;
		pixels     = pixels * geo_h;
		res.data   = '0;
		res.last   = 1'b0;
		res.status = lrhc_pkg::ST_OK;
		if (total == 0) begin
			res.status = lrhc_pkg::ST_SIZE_ERROR;
			expected_q.push_back(res);
		end else if (op == lrhc_pkg::CMD_LOAD) begin
			if (load_cnt < total) begin
				if (geo_d == lrhc_pkg::DIR_HWC_CHW && geo_c > 1) begin
					dest = ch_cnt * pixels + pix_cnt;
					ch_cnt++;
					if (ch_cnt >= geo_c) begin
						ch_cnt = 0;
						pix_cnt++;
					end
				end else if (geo_d == lrhc_pkg::DIR_CHW_HWC && geo_c > 1) begin
					dest = pix_cnt * geo_c + ch_cnt;
					pix_cnt++;
					if (pix_cnt >= pixels) begin
						pix_cnt = 0;
						ch_cnt++;
					end
				end else begin
					dest = load_cnt;
				end
				if (dest < total)
					img_store[dest] = data;
				load_cnt++;
			end
		end else if (load_cnt < total || rd_idx >= total) begin
			res.status = lrhc_pkg::ST_NOT_READY;
			expected_q.push_back(res);
		end else begin
			res.data = img_store[rd_idx];
			if (rd_idx == total - 1) begin
				res.last = 1'b1;
				empty_tensor();
			end else begin
				rd_idx++;
			end
			expected_q.push_back(res);
		end
	endtask

	function automatic logic [lrhc_pkg::ELEMENT_BITS-1:0] rand_elem();
		case ($urandom_range(0, 7))
			0: rand_elem = '0;
			1: rand_elem = '1;
			default: rand_elem = $urandom;
		endcase
	endfunction

	task automatic push_item(input logic op, input logic [lrhc_pkg::ELEMENT_BITS-1:0] data);
		cmd_item_t it;
		it.op   = op;
		it.data = data;
		cmd_queue.push_back(it);
		queued_items++;
	endtask

	task automatic write_reg(input logic [lrhc_pkg::CFG_IDX_W-1:0] idx,
			input logic [lrhc_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_geom(input logic [lrhc_pkg::CNT_W-1:0] w,
			input logic [lrhc_pkg::CNT_W-1:0] h,
			input logic [lrhc_pkg::CHN_W-1:0] c, input logic [lrhc_pkg::DIR_W-1:0] d);
		logic [lrhc_pkg::CFG_DATA_W-1:0] cdata;
		logic [lrhc_pkg::CFG_DATA_W-1:0] ddata;
		cdata = lrhc_pkg::CFG_DATA_W'(c);
		ddata = lrhc_pkg::CFG_DATA_W'(d);
		if ($urandom_range(0, 1) == 0) begin
			cdata = lrhc_pkg::CFG_DATA_W'($urandom);
			ddata = lrhc_pkg::CFG_DATA_W'($urandom);
			cdata[lrhc_pkg::CHN_W-1:0] = c;
			ddata[lrhc_pkg::DIR_W-1:0] = d;
		end
		write_reg(lrhc_pkg::REG_WIDTH, w);
		write_reg(lrhc_pkg::REG_HEIGHT, h);
		write_reg(lrhc_pkg::REG_CHANNELS, cdata);
		write_reg(lrhc_pkg::REG_DIRECTION, ddata);
		if ($urandom_range(0, 3) == 0)
			write_reg(lrhc_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
				lrhc_pkg::CFG_DATA_W'($urandom));
	endtask

	task automatic drain();
		do @(negedge clk); while (cmd_queue.size() != 0 || in_valid || expected_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		cmd_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				predict_reorder(cmd, element);
			if (in_valid && in_stall) begin
				// hold the stalled transfer
			end else if (send_gap != 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(1, 18) - 1;
				in_valid <= 1'b0;
			end else if (cmd_queue.size() != 0) begin
				nxt = cmd_queue.pop_front();
				in_valid <= 1'b1;
				cmd      <= nxt.op;
				element  <= nxt.data;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		reorder_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("result with no pending command, status %0d",
						status));
				end else begin
					want = expected_q.pop_front();
					if (status !== want.status)
						report_mismatch($sformatf("result %0d: status %0d, want %0d",
							result_no, status, want.status));
					if (element_out !== want.data)
						report_mismatch($sformatf("result %0d: element_out %h, want %h",
							result_no, element_out, want.data));
					if (last !== want.last)
						report_mismatch($sformatf("result %0d: last %b, want %b",
							result_no, last, want.last));
				end
				result_no++;
			end
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", idle_cycles);
			$display("layout_reorder_hwc_chw_core_test: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [lrhc_pkg::CNT_W-1:0] w;
		logic [lrhc_pkg::CNT_W-1:0] h;
		logic [lrhc_pkg::CHN_W-1:0] c;
		logic [lrhc_pkg::DIR_W-1:0] d;
		int                         total;
		int                         cut;
		int                         reps;
		int                         base;
		int                         n;

		geo_w = 1;
		geo_h = 1;
		geo_c = 3;
		geo_d = lrhc_pkg::DIR_HWC_CHW;
		empty_tensor();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset geometry 1x1x3
		push_item(lrhc_pkg::CMD_PULL, '1);
		push_item(lrhc_pkg::CMD_LOAD, '0);
		push_item(lrhc_pkg::CMD_LOAD, '1);
		push_item(lrhc_pkg::CMD_LOAD, 32'h5a5a_a5a5);
		push_item(lrhc_pkg::CMD_LOAD, 32'h1234_5678);
		repeat (3) push_item(lrhc_pkg::CMD_PULL, '0);
		push_item(lrhc_pkg::CMD_PULL, '0);
		drain();

		// planar to interleaved, spare register write mid-tensor
		set_geom(2, 1, 2, lrhc_pkg::DIR_CHW_HWC);
		push_item(lrhc_pkg::CMD_LOAD, 32'h0000_0001);
		push_item(lrhc_pkg::CMD_LOAD, 32'h0000_0002);
		drain();
		write_reg(REG_SPARE_FIRST, '1);
		push_item(lrhc_pkg::CMD_LOAD, 32'h8000_0003);
		push_item(lrhc_pkg::CMD_LOAD, 32'h8000_0004);
		repeat (4) push_item(lrhc_pkg::CMD_PULL, rand_elem());
		drain();

		// invalid sizes
		set_geom(0, 1, 1, lrhc_pkg::DIR_HWC_CHW);
		push_item(lrhc_pkg::CMD_LOAD, '1);
		push_item(lrhc_pkg::CMD_PULL, '0);
		drain();
		set_geom(1, 1, 17, DIR_COPY);
		push_item(lrhc_pkg::CMD_PULL, '0);
		drain();
		set_geom(16385, 1, 1, DIR_COPY_ALT);
		push_item(lrhc_pkg::CMD_LOAD, '0);
		drain();
		set_geom(1, 1, 0, lrhc_pkg::DIR_HWC_CHW);
		push_item(lrhc_pkg::CMD_LOAD, '1);
		drain();

		// full capacity, widest channel count: size accepted, partial load
		set_geom(1024, 1, 16, lrhc_pkg::DIR_HWC_CHW);
		repeat (4) push_item(lrhc_pkg::CMD_LOAD, rand_elem());
		push_item(lrhc_pkg::CMD_PULL, rand_elem());
		drain();

		base = queued_items;
		while (queued_items - base < RANDOM_ITEMS) begin
			quiet = (queued_items - base >= QUIET_FROM);
			d = lrhc_pkg::DIR_W'($urandom_range(lrhc_pkg::DIR_HWC_CHW, DIR_COPY_ALT));
			if ($urandom_range(0, 9) == 0) begin
				w = lrhc_pkg::CNT_W'($urandom_range(1, 32767));
				h = lrhc_pkg::CNT_W'($urandom_range(1, 32767));
				c = lrhc_pkg::CHN_W'($urandom_range(1, 16));
				case ($urandom_range(0, 3))
					0: w = 0;
					1: h = 0;
					2: begin
						if ($urandom_range(0, 1) == 0)
							c = 0;
						else
							c = lrhc_pkg::CHN_W'($urandom_range(17, 31));
					end
					default: begin
						if (w < 129)
							w = w + lrhc_pkg::CNT_W'(16384);
					end
				endcase
				set_geom(w, h, c, d);
				n = $urandom_range(1, 6);
				repeat (n) push_item(1'($urandom_range(0, 1)), rand_elem());
			end else begin
				if ($urandom_range(0, 7) == 0) begin
					if ($urandom_range(0, 1) == 0) begin
						w = lrhc_pkg::CNT_W'($urandom_range(1, 64));
						h = 1;
					end else begin
						w = 1;
						h = lrhc_pkg::CNT_W'($urandom_range(1, 64));
					end
					c = lrhc_pkg::CHN_W'($urandom_range(1, 3));
				end else begin
					w = lrhc_pkg::CNT_W'($urandom_range(1, 6));
					h = lrhc_pkg::CNT_W'($urandom_range(1, 6));
					if ($urandom_range(0, 3) == 0)
						c = 1;
					else
						c = lrhc_pkg::CHN_W'($urandom_range(2, 16));
				end
				set_geom(w, h, c, d);
				total = int'(w) * int'(h) * int'(c);
				reps = $urandom_range(1, 2);
				for (int r = 0; r < reps; r++) begin
					cut = total;
					if (r == reps - 1 && $urandom_range(0, 9) == 0)
						cut = $urandom_range(0, total - 1);
					for (int i = 0; i < cut; i++) begin
						if ($urandom_range(0, 19) == 0)
							push_item(lrhc_pkg::CMD_PULL, rand_elem());
						push_item(lrhc_pkg::CMD_LOAD, rand_elem());
					end
					if (cut == total) begin
						if ($urandom_range(0, 3) == 0)
							repeat ($urandom_range(1, 3))
								push_item(lrhc_pkg::CMD_LOAD, rand_elem());
						repeat (total) push_item(lrhc_pkg::CMD_PULL, rand_elem());
						if ($urandom_range(0, 3) == 0)
							push_item(lrhc_pkg::CMD_PULL, rand_elem());
					end
				end
			end
			drain();
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("layout_reorder_hwc_chw_core_test: done, clean");
		else
			$display("layout_reorder_hwc_chw_core_test: done, errors");
		$finish;
	end

endmodule
